@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/core/btbl_pkg.sv @@
// ----------------------------------------------------------------------------
// btbl_pkg
// Shared constants, types and default table contents of the breakpoint
// table interpolator.
// ----------------------------------------------------------------------------
package btbl_pkg;

	localparam int DEF_TABLE_DEPTH = 32;
	localparam int TBL_IDX_MAX_W   = 8;
	localparam int DATA_W          = 16;
	localparam int CFG_W           = 6;

	localparam logic [CFG_W-1:0] CFG_RESET = 6'd24;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] factor;
		logic [DATA_W-1:0] multiplier;
		logic [DATA_W-1:0] divisor;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
	} md_rsp_t;

	function automatic logic [DATA_W-1:0] default_mach(input logic [TBL_IDX_MAX_W-1:0] idx);
		logic [DATA_W-1:0] v;
		case (idx)
			8'd0:    v = 16'd0;
			8'd1:    v = 16'd1638;
			8'd2:    v = 16'd2458;
			8'd3:    v = 16'd2867;
			8'd4:    v = 16'd3277;
			8'd5:    v = 16'd3482;
			8'd6:    v = 16'd3686;
			8'd7:    v = 16'd3768;
			8'd8:    v = 16'd3891;
			8'd9:    v = 16'd3973;
			8'd10:   v = 16'd4096;
			8'd11:   v = 16'd4178;
			8'd12:   v = 16'd4301;
			8'd13:   v = 16'd4506;
			8'd14:   v = 16'd4710;
			8'd15:   v = 16'd4915;
			8'd16:   v = 16'd5325;
			8'd17:   v = 16'd6144;
			8'd18:   v = 16'd7168;
			8'd19:   v = 16'd8192;
			8'd20:   v = 16'd9216;
			8'd21:   v = 16'd10240;
			8'd22:   v = 16'd12288;
			8'd23:   v = 16'd14336;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	function automatic logic [DATA_W-1:0] default_drag(input logic [TBL_IDX_MAX_W-1:0] idx);
		logic [DATA_W-1:0] v;
		case (idx)
			8'd0:    v = 16'd8520;
			8'd1:    v = 16'd8520;
			8'd2:    v = 16'd8585;
			8'd3:    v = 16'd8847;
			8'd4:    v = 16'd9503;
			8'd5:    v = 16'd10355;
			8'd6:    v = 16'd12124;
			8'd7:    v = 16'd13763;
			8'd8:    v = 16'd18350;
			8'd9:    v = 16'd21627;
			8'd10:   v = 16'd25887;
			8'd11:   v = 16'd26870;
			8'd12:   v = 16'd27394;
			8'd13:   v = 16'd26870;
			8'd14:   v = 16'd25887;
			8'd15:   v = 16'd24904;
			8'd16:   v = 16'd23265;
			8'd17:   v = 16'd20972;
			8'd18:   v = 16'd19005;
			8'd19:   v = 16'd17564;
			8'd20:   v = 16'd16384;
			8'd21:   v = 16'd15466;
			8'd22:   v = 16'd14090;
			8'd23:   v = 16'd13107;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/btbl_table.sv @@
// ----------------------------------------------------------------------------
// btbl_table
// Breakpoint/drag storage: one write port, one registered read port.
// Entries never written read back their reset defaults.
// ----------------------------------------------------------------------------
module btbl_table #(
	parameter int TABLE_DEPTH = btbl_pkg::DEF_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  logic [btbl_pkg::DATA_W-1:0]   wr_mach,
	input  logic [btbl_pkg::DATA_W-1:0]   wr_drag,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	output logic [btbl_pkg::DATA_W-1:0]   rd_mach,
	output logic [btbl_pkg::DATA_W-1:0]   rd_drag
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [btbl_pkg::DATA_W-1:0] mach_mem [TABLE_DEPTH];
	logic [btbl_pkg::DATA_W-1:0] drag_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]      valid_q;
	logic                        rd_valid_q;
	logic [IDX_W-1:0]            rd_addr_q;
	logic [btbl_pkg::DATA_W-1:0] rd_mach_q;
	logic [btbl_pkg::DATA_W-1:0] rd_drag_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mach_mem[wr_addr] <= wr_mach;
			drag_mem[wr_addr] <= wr_drag;
		end
		rd_mach_q <= mach_mem[rd_addr];
		rd_drag_q <= drag_mem[rd_addr];
		rd_addr_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_mach = rd_valid_q ? rd_mach_q
		: btbl_pkg::default_mach(btbl_pkg::TBL_IDX_MAX_W'(rd_addr_q));
	assign rd_drag = rd_valid_q ? rd_drag_q
		: btbl_pkg::default_drag(btbl_pkg::TBL_IDX_MAX_W'(rd_addr_q));

endmodule

@@ rtl/core/btbl_muldiv.sv @@
// ----------------------------------------------------------------------------
// btbl_muldiv
// Bit-serial unit: factor * multiplier by shift-add, then restoring division
// of the 32-bit product by the divisor, one bit per cycle each.
// ----------------------------------------------------------------------------
module btbl_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  btbl_pkg::md_req_t req,
	output btbl_pkg::md_rsp_t rsp
);

	localparam int W     = btbl_pkg::DATA_W;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             div_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     mcand_q;
	logic [W-1:0]     span_q;
	logic [W-1:0]     hi_q;
	logic [W-1:0]     lo_q;
	logic [W:0]       mul_sum;
	logic [W:0]       trial;
	logic             qbit;

	assign mul_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
	assign trial   = {hi_q, lo_q[W-1]};
	assign qbit    = trial >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				div_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					if (div_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						div_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q <= req.factor;
			span_q  <= req.divisor;
			hi_q    <= '0;
			lo_q    <= req.multiplier;
		end else if (busy_q) begin
			if (!div_q) begin
				hi_q <= mul_sum[W:1];
				lo_q <= {mul_sum[0], lo_q[W-1:1]};
			end else begin
				hi_q <= qbit ? W'(trial - {1'b0, span_q}) : trial[W-1:0];
				lo_q <= {lo_q[W-2:0], qbit};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = lo_q;

endmodule

@@ rtl/core/breakpoint_table_interpolator.sv @@
// A load word writes its table entry on accept. A query at or below the first point
// returns the first drag value, at or above the last point in use the last one;
// else a table scan (one table read per cycle) and serial mul/div interpolate it.
// One word in flight; input stalls until the result sits in the output register.
// arst_n clears control, restores the default table and sets points_in_use to 24.
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator
// Piecewise linear drag lookup over a Mach breakpoint table with clamping.
// ----------------------------------------------------------------------------
module breakpoint_table_interpolator #(
	parameter int TABLE_DEPTH = btbl_pkg::DEF_TABLE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [btbl_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        op,
	input  logic [4:0]                  entry_index,
	input  logic [btbl_pkg::DATA_W-1:0] mach_value,
	input  logic [btbl_pkg::DATA_W-1:0] drag_value,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [btbl_pkg::DATA_W-1:0] drag_result
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int W     = btbl_pkg::DATA_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIRST = 3'd1;
	localparam logic [2:0] S_LAST  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_CALC  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]                 state_q;
	logic [btbl_pkg::CFG_W-1:0] points_q;
	logic [CNT_W-1:0]           n_eff;
	logic [IDX_W-1:0]           last_idx;
	logic [IDX_W-1:0]           rd_addr;
	logic [IDX_W-1:0]           scan_idx_q;
	logic [W-1:0]               rd_mach;
	logic [W-1:0]               rd_drag;
	logic [W-1:0]               query_q;
	logic [W-1:0]               prev_m_q;
	logic [W-1:0]               prev_d_q;
	logic                       neg_q;
	logic [W-1:0]               res_q;
	logic                       result_valid_q;
	logic [W-1:0]               drag_result_q;
	logic                       item_acc;
	logic                       wr_en;
	logic                       found;
	logic                       out_load;
	btbl_pkg::md_req_t          md_req;
	btbl_pkg::md_rsp_t          md_rsp;

	assign item_stall = state_q != S_IDLE;
	assign item_acc   = item_valid && !item_stall;
	assign wr_en      = item_acc && op == btbl_pkg::OP_LOAD && int'(entry_index) < TABLE_DEPTH;
	assign found      = query_q <= rd_mach;
	assign out_load   = state_q == S_OUT && (!result_valid_q || !result_stall);

	always_comb begin
		if (points_q < btbl_pkg::CFG_W'(2))
			n_eff = CNT_W'(2);
		else if (int'(points_q) > TABLE_DEPTH)
			n_eff = CNT_W'(TABLE_DEPTH);
		else
			n_eff = CNT_W'(points_q);
	end
	assign last_idx = IDX_W'(n_eff - CNT_W'(1));

	always_comb begin
		case (state_q)
			S_FIRST: rd_addr = last_idx;
			S_LAST:  rd_addr = IDX_W'(1);
			S_SCAN:  rd_addr = scan_idx_q + IDX_W'(1);
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		md_req.start      = state_q == S_SCAN && found;
		md_req.factor     = (rd_drag < prev_d_q) ? prev_d_q - rd_drag : rd_drag - prev_d_q;
		md_req.multiplier = query_q - prev_m_q;
		md_req.divisor    = rd_mach - prev_m_q;
	end

	btbl_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(IDX_W'(entry_index)),
		.wr_mach(mach_value),
		.wr_drag(drag_value),
		.rd_addr(rd_addr),
		.rd_mach(rd_mach),
		.rd_drag(rd_drag)
	);

	btbl_muldiv u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.rsp   (md_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			points_q       <= btbl_pkg::CFG_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				points_q <= cfg_wr_data;
			if (out_load)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item_acc && op == btbl_pkg::OP_QUERY)
						state_q <= S_FIRST;
				end
				S_FIRST: begin
					state_q <= found ? S_OUT : S_LAST;
				end
				S_LAST: begin
					state_q <= (query_q >= rd_mach) ? S_OUT : S_SCAN;
				end
				S_SCAN: begin
					if (found)
						state_q <= S_CALC;
				end
				S_CALC: begin
					if (md_rsp.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc)
			query_q <= mach_value;
		if (out_load)
			drag_result_q <= res_q;
		case (state_q)
			S_FIRST: begin
				res_q    <= rd_drag;
				prev_m_q <= rd_mach;
				prev_d_q <= rd_drag;
			end
			S_LAST: begin
				res_q      <= rd_drag;
				scan_idx_q <= IDX_W'(1);
			end
			S_SCAN: begin
				if (found) begin
					neg_q <= rd_drag < prev_d_q;
				end else begin
					prev_m_q   <= rd_mach;
					prev_d_q   <= rd_drag;
					scan_idx_q <= scan_idx_q + IDX_W'(1);
				end
			end
			S_CALC: begin
				if (md_rsp.done)
					res_q <= neg_q ? prev_d_q - md_rsp.quot : prev_d_q + md_rsp.quot;
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign drag_result  = drag_result_q;

endmodule

@@ rtl/core/btbl_checker.sv @@
// ----------------------------------------------------------------------------
// btbl_checker
// Port-level checks of the breakpoint table interpolator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btbl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_stall,
	input logic                        op,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [btbl_pkg::DATA_W-1:0] drag_result
);

	logic item_acc;

	assign item_acc = item_valid && !item_stall;

	// a stalled result word holds
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(drag_result))

	// a load never produces a result word
	`ASSERT_NEXT(a_load_silent, clk, arst_n, item_acc && op == btbl_pkg::OP_LOAD && !result_valid, !result_valid)

	// a query occupies the block
	`ASSERT_NEXT(a_query_busy, clk, arst_n, item_acc && op == btbl_pkg::OP_QUERY, item_stall)

	// a new result only appears from a busy block
	`ASSERT_SAME(a_result_src, clk, arst_n, $rose(result_valid), $past(item_stall))

endmodule

bind breakpoint_table_interpolator btbl_checker u_btbl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.op          (op),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.drag_result (drag_result)
);
